// ===== rtl/ray_box_nearest_hit_top_assert.svh =====
// Assertion macros used by the top file to check its own logic.
`ifndef RAY_BOX_NEAREST_HIT_TOP_ASSERT_SVH
`define RAY_BOX_NEAREST_HIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RBNH_AST_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbnh assertion failed");

// Next-cycle implication, disabled during reset.
`define RBNH_AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbnh assertion failed");

`endif

// ===== rtl/rbnh_pkg.sv =====
`timescale 1ns / 1ps

package rbnh_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int ID_WIDTH    = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_AXES    = 3;

    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 1;
    localparam int SHIFT_WIDTH = PROD_WIDTH - FRAC_BITS;

    localparam int CFG_IDX_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_WIDTH-1:0]  t_diff;
    typedef logic signed [PROD_WIDTH-1:0]  t_prod;
    typedef logic signed [SHIFT_WIDTH-1:0] t_shift;
    typedef logic [ID_WIDTH-1:0]           t_id;
    typedef logic [CFG_IDX_WIDTH-1:0]      t_cfg_idx;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_shift SHIFT_MAX = SHIFT_WIDTH'(COORD_MAX);
    localparam t_shift SHIFT_MIN = SHIFT_WIDTH'(COORD_MIN);
    localparam t_prod  TRUNC_BIAS = t_prod'({FRAC_BITS{1'b1}});

    // Register indexes of the configuration port
    localparam t_cfg_idx CFG_ORIGIN_X  = 3'd0;
    localparam t_cfg_idx CFG_ORIGIN_Y  = 3'd1;
    localparam t_cfg_idx CFG_ORIGIN_Z  = 3'd2;
    localparam t_cfg_idx CFG_INV_DIR_X = 3'd3;
    localparam t_cfg_idx CFG_INV_DIR_Y = 3'd4;
    localparam t_cfg_idx CFG_INV_DIR_Z = 3'd5;

    // Box flags travelling alongside the slab datapath
    typedef struct packed {
        logic visible;
        logic first;
        t_id  id;
    } t_side;

    // Tested box handed to the nearest-hit tracker
    typedef struct packed {
        logic   vld;
        logic   first;
        logic   hit;
        t_coord hit_dist;
        t_id    id;
    } t_hit_item;

    // Shift right by the fraction, rounding toward zero, then saturate
    function automatic t_coord slab_sat(input t_prod p);
        t_prod  biased;
        t_shift q;
        biased = p + (p[PROD_WIDTH-1] ? TRUNC_BIAS : '0);
        q      = t_shift'(biased[PROD_WIDTH-1:FRAC_BITS]);
        if (q > SHIFT_MAX) begin
            return COORD_MAX;
        end else if (q < SHIFT_MIN) begin
            return COORD_MIN;
        end
        return q[COORD_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/ray_box_nearest_hit_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// box       in         i_box_valid / o_box_stall  corners, entity id, visible, first
// result    out        o_res_valid / i_res_stall  box hit and distance, nearest hit
// config    in         i_cfg_valid / o_cfg_ready  register index, write data
//
// One box per cycle while o_box_stall is low; a taken box passes the input register, slab
// products, saturated slab pair, tested box (after the intersection) and result register.
// The nearest-hit compare closes on itself in the result stage.
// Synchronous active-low reset clears the pipeline valids, the ray and the nearest hit.
// A stalled result parks the next one in a skid stage; while it is full the
// whole pipeline holds and o_box_stall is high.
module ray_box_nearest_hit_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  rbnh_pkg::t_cfg_idx         i_cfg_index,
    input  rbnh_pkg::t_coord           i_cfg_data,
    input  logic                       i_box_valid,
    output logic                       o_box_stall,
    input  rbnh_pkg::t_coord           i_box_min_x,
    input  rbnh_pkg::t_coord           i_box_min_y,
    input  rbnh_pkg::t_coord           i_box_min_z,
    input  rbnh_pkg::t_coord           i_box_max_x,
    input  rbnh_pkg::t_coord           i_box_max_y,
    input  rbnh_pkg::t_coord           i_box_max_z,
    input  rbnh_pkg::t_id              i_entity_id,
    input  logic                       i_visible,
    input  logic                       i_first,
    output logic                       o_res_valid,
    input  logic                       i_res_stall,
    output logic                       o_res_box_hit,
    output rbnh_pkg::t_coord           o_res_box_distance,
    output logic                       o_res_nearest_found,
    output rbnh_pkg::t_coord           o_res_nearest_distance,
    output rbnh_pkg::t_id              o_res_nearest_id
);

    `include "ray_box_nearest_hit_top_assert.svh"

    localparam int NA     = rbnh_pkg::NUM_AXES;
    localparam int STAGES = 3;

    rbnh_pkg::t_coord r_origin [NA];
    rbnh_pkg::t_coord r_inv    [NA];

    rbnh_pkg::t_coord r_lo [NA];
    rbnh_pkg::t_coord r_hi [NA];
    logic             r_vld  [STAGES];
    rbnh_pkg::t_side  r_side [STAGES];

    rbnh_pkg::t_coord tmin [NA];
    rbnh_pkg::t_coord tmax [NA];
    logic             isect_hit;
    rbnh_pkg::t_coord isect_dist;

    rbnh_pkg::t_hit_item r_s4;
    logic                advance;

    logic near_within_hit;
    logic search_at_reset;

    assign o_cfg_ready = 1'b1;
    assign o_box_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_origin[a] <= '0;
                r_inv[a]    <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rbnh_pkg::CFG_ORIGIN_X:  r_origin[0] <= i_cfg_data;
                rbnh_pkg::CFG_ORIGIN_Y:  r_origin[1] <= i_cfg_data;
                rbnh_pkg::CFG_ORIGIN_Z:  r_origin[2] <= i_cfg_data;
                rbnh_pkg::CFG_INV_DIR_X: r_inv[0]    <= i_cfg_data;
                rbnh_pkg::CFG_INV_DIR_Y: r_inv[1]    <= i_cfg_data;
                rbnh_pkg::CFG_INV_DIR_Z: r_inv[2]    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // valid chain: input register, products, slab pair, tested box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_s4.vld <= 1'b0;
        end else if (advance) begin
            r_vld[0] <= i_box_valid;
            for (int s = 1; s < STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            r_s4.vld <= r_vld[STAGES-1];
            // an invisible box is passed on but never counts as a hit
            r_s4.first    <= r_side[STAGES-1].first;
            r_s4.id       <= r_side[STAGES-1].id;
            r_s4.hit      <= r_side[STAGES-1].visible && isect_hit;
            r_s4.hit_dist <= (r_side[STAGES-1].visible && isect_hit) ? isect_dist : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lo[0]   <= i_box_min_x;
            r_lo[1]   <= i_box_min_y;
            r_lo[2]   <= i_box_min_z;
            r_hi[0]   <= i_box_max_x;
            r_hi[1]   <= i_box_max_y;
            r_hi[2]   <= i_box_max_z;
            r_side[0] <= '{visible: i_visible, first: i_first, id: i_entity_id};
            for (int s = 1; s < STAGES; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    for (genvar a = 0; a < NA; a++) begin : g_axis
        rbnh_slab u_slab (
            .i_clk    (i_clk),
            .i_en     (advance),
            .i_lo     (r_lo[a]),
            .i_hi     (r_hi[a]),
            .i_origin (r_origin[a]),
            .i_inv    (r_inv[a]),
            .o_tmin   (tmin[a]),
            .o_tmax   (tmax[a])
        );
    end

    rbnh_intersect u_intersect (
        .i_tmin (tmin),
        .i_tmax (tmax),
        .o_hit  (isect_hit),
        .o_dist (isect_dist)
    );

    rbnh_nearest u_nearest (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_item                 (r_s4),
        .o_advance              (advance),
        .o_res_valid            (o_res_valid),
        .i_res_stall            (i_res_stall),
        .o_res_box_hit          (o_res_box_hit),
        .o_res_box_distance     (o_res_box_distance),
        .o_res_nearest_found    (o_res_nearest_found),
        .o_res_nearest_distance (o_res_nearest_distance),
        .o_res_nearest_id       (o_res_nearest_id)
    );

    assign near_within_hit = o_res_nearest_distance <= o_res_box_distance;
    assign search_at_reset = (o_res_nearest_distance == rbnh_pkg::COORD_MAX)
                             && (o_res_nearest_id == '0);

    `RBNH_AST_SAME(a_skid_needs_out, o_box_stall, o_res_valid)
    `RBNH_AST_SAME(a_skid_fill_cause, $rose(o_box_stall), $past(o_res_valid && i_res_stall))
    `RBNH_AST_SAME(a_miss_zero, o_res_valid && !o_res_box_hit, o_res_box_distance == '0)
    `RBNH_AST_SAME(a_nearest_le_hit, o_res_valid && o_res_box_hit, near_within_hit)
    `RBNH_AST_SAME(a_empty_search, o_res_valid && !o_res_nearest_found, search_at_reset)

endmodule

// ===== rtl/rbnh_slab.sv =====
`timescale 1ns / 1ps

// One axis: products in the first register, saturated and ordered pair in the second.
module rbnh_slab (
    input  logic            i_clk,
    input  logic            i_en,
    input  rbnh_pkg::t_coord i_lo,
    input  rbnh_pkg::t_coord i_hi,
    input  rbnh_pkg::t_coord i_origin,
    input  rbnh_pkg::t_coord i_inv,
    output rbnh_pkg::t_coord o_tmin,
    output rbnh_pkg::t_coord o_tmax
);

    rbnh_pkg::t_diff  n_d_lo, n_d_hi;
    rbnh_pkg::t_prod  r_p_lo, r_p_hi;
    rbnh_pkg::t_coord n_t_lo, n_t_hi;
    rbnh_pkg::t_coord r_tmin, r_tmax;

    always_comb begin
        n_d_lo = rbnh_pkg::t_diff'(i_lo) - rbnh_pkg::t_diff'(i_origin);
        n_d_hi = rbnh_pkg::t_diff'(i_hi) - rbnh_pkg::t_diff'(i_origin);
        n_t_lo = rbnh_pkg::slab_sat(r_p_lo);
        n_t_hi = rbnh_pkg::slab_sat(r_p_hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_lo <= rbnh_pkg::t_prod'(n_d_lo) * rbnh_pkg::t_prod'(i_inv);
            r_p_hi <= rbnh_pkg::t_prod'(n_d_hi) * rbnh_pkg::t_prod'(i_inv);
            // order the pair so an inverted box or a negative direction still works
            if (n_t_lo > n_t_hi) begin
                r_tmin <= n_t_hi;
                r_tmax <= n_t_lo;
            end else begin
                r_tmin <= n_t_lo;
                r_tmax <= n_t_hi;
            end
        end
    end

    assign o_tmin = r_tmin;
    assign o_tmax = r_tmax;

endmodule

// ===== rtl/rbnh_intersect.sv =====
`timescale 1ns / 1ps

// Overlap of the three slab intervals, x first, then y, then z.
module rbnh_intersect (
    input  rbnh_pkg::t_coord i_tmin [rbnh_pkg::NUM_AXES],
    input  rbnh_pkg::t_coord i_tmax [rbnh_pkg::NUM_AXES],
    output logic             o_hit,
    output rbnh_pkg::t_coord o_dist
);

    rbnh_pkg::t_coord lo1, hi1, lo2, hi2;
    logic             miss1, miss2;

    always_comb begin
        miss1 = (i_tmin[0] > i_tmax[1]) || (i_tmin[1] > i_tmax[0]);
        lo1   = (i_tmin[1] > i_tmin[0]) ? i_tmin[1] : i_tmin[0];
        hi1   = (i_tmax[1] < i_tmax[0]) ? i_tmax[1] : i_tmax[0];
        miss2 = (lo1 > i_tmax[2]) || (i_tmin[2] > hi1);
        lo2   = (i_tmin[2] > lo1) ? i_tmin[2] : lo1;
        hi2   = (i_tmax[2] < hi1) ? i_tmax[2] : hi1;
        // drop boxes that lie wholly behind the origin
        o_hit  = !miss1 && !miss2 && !hi2[rbnh_pkg::COORD_WIDTH-1];
        o_dist = lo2[rbnh_pkg::COORD_WIDTH-1] ? hi2 : lo2;
    end

endmodule

// ===== rtl/rbnh_nearest.sv =====
`timescale 1ns / 1ps

// Nearest-hit state, result register and skid stage.
module rbnh_nearest (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbnh_pkg::t_hit_item i_item,
    output logic                o_advance,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output logic                o_res_box_hit,
    output rbnh_pkg::t_coord    o_res_box_distance,
    output logic                o_res_nearest_found,
    output rbnh_pkg::t_coord    o_res_nearest_distance,
    output rbnh_pkg::t_id       o_res_nearest_id
);

    typedef struct packed {
        logic             box_hit;
        rbnh_pkg::t_coord box_dist;
        logic             found;
        rbnh_pkg::t_coord best_dist;
        rbnh_pkg::t_id    best_id;
    } t_res;

    logic             r_found;
    rbnh_pkg::t_coord r_best_dist;
    rbnh_pkg::t_id    r_best_id;

    logic             base_found, n_found;
    rbnh_pkg::t_coord base_dist, n_best_dist;
    rbnh_pkg::t_id    base_id, n_best_id;

    logic  r_out_vld, r_skid_vld;
    t_res  r_out, r_skid, n_res;
    logic  take, out_free;

    assign o_advance = !r_skid_vld;
    assign take      = o_advance && i_item.vld;
    assign out_free  = !r_out_vld || !i_res_stall;

    always_comb begin
        if (i_item.first) begin
            base_found = 1'b0;
            base_dist  = rbnh_pkg::COORD_MAX;
            base_id    = '0;
        end else begin
            base_found = r_found;
            base_dist  = r_best_dist;
            base_id    = r_best_id;
        end
        n_found     = base_found;
        n_best_dist = base_dist;
        n_best_id   = base_id;
        // strict less-than keeps the earlier box on a tie
        if (i_item.hit && (i_item.hit_dist < base_dist)) begin
            n_found     = 1'b1;
            n_best_dist = i_item.hit_dist;
            n_best_id   = i_item.id;
        end
        n_res = '{box_hit: i_item.hit, box_dist: i_item.hit_dist, found: n_found,
                  best_dist: n_best_dist, best_id: n_best_id};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_best_dist <= rbnh_pkg::COORD_MAX;
            r_best_id   <= '0;
        end else if (take) begin
            r_found     <= n_found;
            r_best_dist <= n_best_dist;
            r_best_id   <= n_best_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            // drain the skid stage once the result is taken
            if (!i_res_stall) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (take) begin
            if (out_free) begin
                r_out     <= n_res;
                r_out_vld <= 1'b1;
            end else begin
                r_skid     <= n_res;
                r_skid_vld <= 1'b1;
            end
        end else if (out_free) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_res_valid            = r_out_vld;
    assign o_res_box_hit          = r_out.box_hit;
    assign o_res_box_distance     = r_out.box_dist;
    assign o_res_nearest_found    = r_out.found;
    assign o_res_nearest_distance = r_out.best_dist;
    assign o_res_nearest_id       = r_out.best_id;

endmodule
